/* hdl/dht11_edge_time_decoder_macros.svh */
// Assertion macros used by the edge time decoder controller.
`ifndef DHT11_EDGE_TIME_DECODER_MACROS_SVH
`define DHT11_EDGE_TIME_DECODER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define DHTD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("dhtd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DHTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dhtd assertion failed");

`endif

/* hdl/dhtd_pkg.sv */
// Package with the types, codes and constants of the edge time decoder.
package dhtd_pkg;

    // Frame geometry and register reset value.
    localparam int          EDGE_SLOTS_DEF  = 84;
    localparam int          MIN_EDGES       = 81;
    localparam int          DATA_EDGES      = 80;
    localparam int          TIME_W          = 32;
    localparam int          FRAME_BITS      = 40;
    localparam logic [31:0] THRESHOLD_RESET = 32'd50000;

    // Input action codes.
    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_EDGE    = 2'd1,
        ACT_TIMEOUT = 2'd2
    } t_action;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] edge_time;
    } t_in;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] humidity;
        logic [7:0] temperature;
        logic       frame_error;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_count;
        logic store_edge;
        logic start_parse;
        logic read_en;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic short_now;
        logic at_last_edge;
        logic last_read;
    } t_sts;

endpackage

/* hdl/dhtd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dhtd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 84
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/dhtd_dp.sv */
// Datapath: edge count, timestamp store, serial interval decode and output register.
module dhtd_dp #(
    parameter int EDGE_SLOTS = dhtd_pkg::EDGE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [31:0]                   i_cfg_data,
    input  logic [dhtd_pkg::TIME_W-1:0]   i_edge_time,
    input  dhtd_pkg::t_cmd                i_cmd,
    output dhtd_pkg::t_sts                o_sts,
    output dhtd_pkg::t_out                o_out_data
);

    localparam int CW = $clog2(EDGE_SLOTS + 1);
    localparam int AW = $clog2(EDGE_SLOTS);
    localparam int RW = $clog2(dhtd_pkg::DATA_EDGES);
    localparam int TW = dhtd_pkg::TIME_W;
    localparam int FB = dhtd_pkg::FRAME_BITS;

    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_addr;
    logic [RW-1:0]  r_rd_cnt;
    logic           r_rd_vld;
    logic           r_rd_odd;
    logic [TW-1:0]  r_prev;
    logic [FB-1:0]  r_bits;
    logic           r_short;
    logic [31:0]    r_thresh;
    dhtd_pkg::t_out r_out;
    logic [TW-1:0]  rdata;
    logic [TW-1:0]  span;
    logic [7:0]     sum;
    logic           bad;

    // Edge count follows start, edge and finished parse.
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear_count || i_cmd.load_out) begin
            n_count = '0;
        end else if (i_cmd.store_edge) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_thresh <= dhtd_pkg::THRESHOLD_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
        end
    end

    // Timestamp store, written at the current count.
    dhtd_ram #(
        .WIDTH (TW),
        .DEPTH (EDGE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_edge),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_edge_time),
        .i_re    (i_cmd.read_en),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // Read sequencer: 80 consecutive slots, starting one before the first data edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.read_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_parse) begin
            r_addr   <= AW'(n_count - CW'(dhtd_pkg::MIN_EDGES));
            r_rd_cnt <= '0;
            r_short  <= (n_count < CW'(dhtd_pkg::MIN_EDGES));
        end else if (i_cmd.read_en) begin
            r_addr   <= r_addr + AW'(1);
            r_rd_cnt <= r_rd_cnt + RW'(1);
        end
        if (i_cmd.read_en) begin
            r_rd_odd <= r_rd_cnt[0];
        end
    end

    // Even reads hold the earlier edge; odd reads close a pair and give one bit.
    assign span = rdata - r_prev;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (!r_rd_odd) begin
                r_prev <= rdata;
            end else begin
                r_bits <= {r_bits[FB-2:0], (span > r_thresh)};
            end
        end
    end

    // Checksum of the first four bytes against the fifth.
    assign sum = r_bits[39:32] + r_bits[31:24] + r_bits[23:16] + r_bits[15:8];
    assign bad = r_short || (sum != r_bits[7:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (bad) begin
                r_out.humidity    <= 8'hFF;
                r_out.temperature <= 8'hFF;
                r_out.frame_error <= 1'b1;
            end else begin
                r_out.humidity    <= r_bits[39:32];
                r_out.temperature <= r_bits[23:16];
                r_out.frame_error <= 1'b0;
            end
        end
    end

    assign o_out_data         = r_out;
    assign o_sts.short_now    = (r_count < CW'(dhtd_pkg::MIN_EDGES));
    assign o_sts.at_last_edge = (r_count == CW'(EDGE_SLOTS - 1));
    assign o_sts.last_read    = (r_rd_cnt == RW'(dhtd_pkg::DATA_EDGES - 1));

endmodule

/* hdl/dhtd_ctrl.sv */
// Controller: accepts transactions, sequences the parse and owns output valid.
`include "dht11_edge_time_decoder_macros.svh"

module dhtd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_action,
    output logic           o_in_stall,
    input  dhtd_pkg::t_sts i_sts,
    output dhtd_pkg::t_cmd o_cmd,
    output logic           o_out_valid,
    input  logic           i_out_stall
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    logic           r_out_valid, n_out_valid;
    logic           accept;
    logic           out_free;
    dhtd_pkg::t_cmd cmd;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        dhtd_pkg::ACT_START: begin
                            cmd.clear_count = 1'b1;
                        end
                        dhtd_pkg::ACT_EDGE: begin
                            cmd.store_edge = 1'b1;
                            if (i_sts.at_last_edge) begin
                                cmd.start_parse = 1'b1;
                                n_state         = ST_READ;
                            end
                        end
                        dhtd_pkg::ACT_TIMEOUT: begin
                            cmd.start_parse = 1'b1;
                            n_state         = i_sts.short_now ? ST_FINISH : ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd.read_en = 1'b1;
                if (i_sts.last_read) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid holds until the result transaction completes.
    assign n_out_valid = (r_out_valid && i_out_stall) || cmd.load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    // A finished parse with a free output register shows its result next cycle.
    `DHTD_ASSERT_NEXT(a_finish_loads, (r_state == ST_FINISH) && out_free, o_out_valid)
    // The last read moves the sequencer on to drain the RAM pipeline.
    `DHTD_ASSERT_NEXT(a_read_ends, (r_state == ST_READ) && i_sts.last_read, r_state == ST_DRAIN)
    // No edge is stored while a parse is running.
    `DHTD_ASSERT_ALWAYS(a_no_store_busy, (r_state == ST_IDLE) || !o_cmd.store_edge)

endmodule

/* hdl/dht11_edge_time_decoder.sv */
// Start and edge transactions are accepted one per cycle while idle.
// A parse reads 80 timestamps serially from the edge RAM, one per cycle, then
// drains the RAM read register and loads the result when the output is free;
// a short frame skips the reads. Input stalls until the result is loaded.
// Reset (synchronous, active low) clears the edge count, the sequencer, output
// valid and sets the threshold to 50000; the timestamp RAM is not cleared.
module dht11_edge_time_decoder #(
    parameter int EDGE_SLOTS = dhtd_pkg::EDGE_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dhtd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dhtd_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_data
);

    dhtd_pkg::t_cmd cmd;
    dhtd_pkg::t_sts sts;

    // Sequencing and handshakes.
    dhtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

    // Storage and decode.
    dhtd_dp #(
        .EDGE_SLOTS (EDGE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_edge_time (i_in_data.edge_time),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule
